// ----- design/qec_pkg.sv -----
// ----------------------------------------------------------------------------
// qec_pkg: shared definitions for the quadratic easing curve
// Widths, register indexes, curve codes and the record that travels
// down the divider cell chain.
// ----------------------------------------------------------------------------
package qec_pkg;

    localparam int TIME_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_W     = TIME_W + FRAC_W;
    localparam int SQ_W      = 2 * FRAC_W;

    localparam logic [CFG_IDX_W-1:0] REG_DURATION = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CURVE    = CFG_IDX_W'(1);

    localparam logic [TIME_W-1:0] DUR_RESET  = TIME_W'(32'd1000);
    localparam logic [FRAC_W-1:0] FULL_SCALE = {FRAC_W{1'b1}};
    localparam logic [FRAC_W-1:0] HALF_POINT = FRAC_W'(1) << (FRAC_W - 1);
    localparam logic [SQ_W-1:0]   ROUND_HI   = SQ_W'(1) << (FRAC_W - 1);
    localparam logic [SQ_W-1:0]   ROUND_LO   = SQ_W'(1) << (FRAC_W - 2);

    typedef enum logic [1:0] {
        CURVE_LINEAR   = 2'd0,
        CURVE_QUAD_IN  = 2'd1,
        CURVE_QUAD_OUT = 2'd2,
        CURVE_IN_OUT   = 2'd3
    } curve_t;

    typedef struct packed {
        logic [TIME_W-1:0] rem;
        logic [FRAC_W-1:0] num_lo;
        logic [FRAC_W-1:0] quo;
        logic              zero;
    } div_t;

endpackage

// ----- design/qec_div_cell.sv -----
// ----------------------------------------------------------------------------
// qec_div_cell: one restoring division step
// Brings down one dividend bit, subtracts the duration when it fits and
// shifts the resulting quotient bit into the partial quotient.
// ----------------------------------------------------------------------------
module qec_div_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        up_valid,
    output logic                        up_ready,
    input  qec_pkg::div_t               up_data,
    input  logic [qec_pkg::TIME_W-1:0]  divisor,
    output logic                        dn_valid,
    input  logic                        dn_ready,
    output qec_pkg::div_t               dn_data
);
    import qec_pkg::*;

    logic              valid_reg;
    div_t              data_reg;
    div_t              data_next;
    logic [TIME_W:0]   trial;
    logic [TIME_W:0]   diff;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        trial     = {up_data.rem, up_data.num_lo[FRAC_W-1]};
        diff      = trial - {1'b0, divisor};
        data_next = up_data;
        data_next.num_lo = {up_data.num_lo[FRAC_W-2:0], 1'b0};
        if (!diff[TIME_W])
        begin
            data_next.rem = diff[TIME_W-1:0];
            data_next.quo = {up_data.quo[FRAC_W-2:0], 1'b1};
        end
        else
        begin
            data_next.rem = trial[TIME_W-1:0];
            data_next.quo = {up_data.quo[FRAC_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- design/qec_ease.sv -----
// ----------------------------------------------------------------------------
// qec_ease: curve stage
// Squares the progress or its complement in one stage, then rounds, scales and
// mirrors it as needed into the output register; linear passes it through.
// ----------------------------------------------------------------------------
module qec_ease (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        up_valid,
    output logic                        up_ready,
    input  qec_pkg::div_t               up_data,
    input  qec_pkg::curve_t             curve_mode,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [qec_pkg::FRAC_W-1:0]  eased_value
);
    import qec_pkg::*;

    logic              s1_valid_reg;
    logic [FRAC_W-1:0] s1_p_reg;
    logic [SQ_W-1:0]   s1_sq_reg;
    curve_t            s1_mode_reg;
    logic              s1_low_reg;
    logic              s1_ready;

    logic              out_valid_reg;
    logic [FRAC_W-1:0] out_value_reg;
    logic [FRAC_W-1:0] out_value_next;

    logic [FRAC_W-1:0] p;
    logic [FRAC_W-1:0] q;
    logic [FRAC_W-1:0] op;
    logic              low;
    logic [SQ_W-1:0]   rnd_hi;
    logic [SQ_W-1:0]   rnd_lo;

    assign s1_ready    = !out_valid_reg || out_ready;
    assign up_ready    = !s1_valid_reg || s1_ready;
    assign out_valid   = out_valid_reg;
    assign eased_value = out_value_reg;

    always_comb
    begin
        p   = up_data.zero ? '0 : up_data.quo;
        q   = FULL_SCALE - p;
        low = p < HALF_POINT;
        if (curve_mode == CURVE_QUAD_IN || (curve_mode == CURVE_IN_OUT && low))
        begin
            op = p;
        end
        else
        begin
            op = q;
        end
    end

    always_comb
    begin
        rnd_hi = s1_sq_reg + ROUND_HI;
        rnd_lo = s1_sq_reg + ROUND_LO;
        case (s1_mode_reg)
            CURVE_LINEAR:   out_value_next = s1_p_reg;
            CURVE_QUAD_IN:  out_value_next = rnd_hi[SQ_W-1:FRAC_W];
            CURVE_QUAD_OUT: out_value_next = FULL_SCALE - rnd_hi[SQ_W-1:FRAC_W];
            CURVE_IN_OUT:
            begin
                if (s1_low_reg)
                begin
                    out_value_next = rnd_lo[SQ_W-2:FRAC_W-1];
                end
                else
                begin
                    out_value_next = FULL_SCALE - rnd_lo[SQ_W-2:FRAC_W-1];
                end
            end
            default:        out_value_next = s1_p_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (up_ready)
            begin
                s1_valid_reg <= up_valid;
            end
            if (s1_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            s1_p_reg    <= p;
            s1_sq_reg   <= SQ_W'(op) * SQ_W'(op);
            s1_mode_reg <= curve_mode;
            s1_low_reg  <= low;
        end
        if (s1_valid_reg && s1_ready)
        begin
            out_value_reg <= out_value_next;
        end
    end

    a_linear_passes: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_ready && s1_mode_reg == CURVE_LINEAR)
        |=> (out_value_reg == $past(s1_p_reg)))
        else $error("linear curve changed the progress value");

    a_quad_in_below: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_ready && s1_mode_reg == CURVE_QUAD_IN)
        |=> (out_value_reg <= $past(s1_p_reg)))
        else $error("quadratic in rose above the progress value");

    a_quad_out_above: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_ready && s1_mode_reg == CURVE_QUAD_OUT)
        |=> (out_value_reg >= $past(s1_p_reg)))
        else $error("quadratic out fell below the progress value");

endmodule

// ----- design/quadratic_easing_curve.sv -----
// ----------------------------------------------------------------------------
// quadratic_easing_curve: eased progress from elapsed time
// Clamps the elapsed time to the duration, scales it to a 16-bit progress
// through a chain of division cells and applies the selected curve.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    elapsed_ms [31:0]
//   output    out_valid / out_ready  eased_value [15:0]
//   config    cfg_we                 cfg_index [1:0], cfg_data [31:0]
//
// One request per cycle is accepted while the output is not stalled; each result
// passes a scaling stage, 16 division cells, a squaring stage and the output
// stage.
// Reset empties every stage and sets duration to 1000 and the curve to linear.
// A stalled output holds its stage; each stage takes a new request whenever
// it is empty or its successor moves, so bubbles close up before input stalls.
// ----------------------------------------------------------------------------
module quadratic_easing_curve (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [31:0]                    elapsed_ms,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [15:0]                    eased_value,
    input  logic                           cfg_we,
    input  logic [qec_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qec_pkg::CFG_W-1:0]      cfg_data
);
    import qec_pkg::*;

    logic [TIME_W-1:0] dur_reg;
    curve_t            curve_reg;

    logic              s0_valid_reg;
    div_t              s0_data_reg;
    div_t              s0_data_next;
    logic [TIME_W-1:0] t_in;
    logic [TIME_W-1:0] t_clamp;
    logic [NUM_W-1:0]  num;

    logic              cell_valid [0:FRAC_W];
    logic              cell_ready [0:FRAC_W];
    div_t              cell_data  [0:FRAC_W];

    assign in_ready      = !s0_valid_reg || cell_ready[0];
    assign cell_valid[0] = s0_valid_reg;
    assign cell_data[0]  = s0_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_reg   <= DUR_RESET;
            curve_reg <= CURVE_LINEAR;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_DURATION)
            begin
                dur_reg <= cfg_data[TIME_W-1:0];
            end
            else if (cfg_index == REG_CURVE)
            begin
                curve_reg <= curve_t'(cfg_data[1:0]);
            end
        end
    end

    always_comb
    begin
        t_in    = elapsed_ms[TIME_W-1:0];
        t_clamp = (t_in > dur_reg) ? dur_reg : t_in;
        num     = {t_clamp, {FRAC_W{1'b0}}} - {{FRAC_W{1'b0}}, t_clamp};
        s0_data_next.rem    = num[NUM_W-1:FRAC_W];
        s0_data_next.num_lo = num[FRAC_W-1:0];
        s0_data_next.quo    = '0;
        s0_data_next.zero   = (dur_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s0_data_reg <= s0_data_next;
        end
    end

    for (genvar i = 0; i < FRAC_W; i++)
    begin : g_cell
        qec_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (cell_valid[i]),
            .up_ready (cell_ready[i]),
            .up_data  (cell_data[i]),
            .divisor  (dur_reg),
            .dn_valid (cell_valid[i+1]),
            .dn_ready (cell_ready[i+1]),
            .dn_data  (cell_data[i+1])
        );
    end

    qec_ease u_ease (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (cell_valid[FRAC_W]),
        .up_ready    (cell_ready[FRAC_W]),
        .up_data     (cell_data[FRAC_W]),
        .curve_mode  (curve_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .eased_value (eased_value)
    );

endmodule
